// ----- sv/assert_macros.svh -----
// Assertion helpers included by the table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, but also active while reset is applied.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/tpt_pkg.sv -----
package tpt_pkg;

    localparam int DEF_MAX_TAGS = 32;
    localparam int ENTRY_W = 64;
    localparam logic [31:0] STALE_RESET = 32'd600;

    localparam logic [2:0] OP_UPDATE = 3'd0;
    localparam logic [2:0] OP_AGE = 3'd1;
    localparam logic [2:0] OP_SORT_TIME = 3'd2;
    localparam logic [2:0] OP_SORT_RSSI = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    localparam logic [1:0] UPD_FULL = 2'd0;
    localparam logic [1:0] UPD_ADDED = 2'd1;
    localparam logic [1:0] UPD_UPDATED = 2'd2;

    typedef struct packed {
        logic [15:0] tag_id;
        logic [7:0] rssi;
        logic [7:0] status;
        logic [31:0] last_seen;
    } t_entry;

endpackage

// ----- sv/tpt_ram.sv -----
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tag_presence_table_with_aging.sv -----
// Tag presence table: up to MAX_TAGS entries (id, strongest rssi, status,
// last-seen second) held in one single-port-write, registered-read memory.
// A request is taken only when the block is idle and one result is returned
// per request. Every memory access is a read followed by a step that uses
// the data, so the latency follows the entry count N: update and age-out
// scan the entries in turn, while read and unused codes scan none. A sort
// is an insertion sort done one compare-and-swap at a time, each one
// passing through the read, latch, compare and write-back states; already
// ordered tables cost least. The single memory read port sets all these
// costs. While a result waits for i_ready the block holds it and takes no
// new request. The age threshold register resets to 600 seconds and is
// written through its own channel.
module tag_presence_table_with_aging
    import tpt_pkg::*;
#(
    parameter int MAX_TAGS = DEF_MAX_TAGS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_op,
    input  logic [15:0]       i_tag_id,
    input  logic signed [7:0] i_rssi,
    input  logic [7:0]        i_status,
    input  logic [31:0]       i_now_sec,
    input  logic [4:0]        i_entry_index,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [31:0]       i_cfg_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_update_code,
    output logic [5:0]        o_removed_count,
    output logic [5:0]        o_entry_count,
    output logic              o_read_valid,
    output logic [15:0]       o_read_tag_id,
    output logic signed [7:0] o_read_rssi,
    output logic [7:0]        o_read_status,
    output logic [31:0]       o_read_last_seen
);

`include "assert_macros.svh"

    localparam int AW = $clog2(MAX_TAGS);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_TAGS);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UPD_RD = 4'd1;   // issue read of index r_i
    localparam logic [3:0] S_UPD_CK = 4'd2;   // compare read data
    localparam logic [3:0] S_AGE_RD = 4'd3;
    localparam logic [3:0] S_AGE_CK = 4'd4;
    localparam logic [3:0] S_RD_WAIT = 4'd5;
    localparam logic [3:0] S_RD_DONE = 4'd6;
    localparam logic [3:0] S_SRT_RA = 4'd7;   // read entry j-1
    localparam logic [3:0] S_SRT_RB = 4'd8;   // read entry j, latch j-1
    localparam logic [3:0] S_SRT_CK = 4'd9;   // compare, maybe write j-1
    localparam logic [3:0] S_SRT_WB = 4'd10;  // write j
    localparam logic [3:0] S_OUT = 4'd11;

    logic [3:0]  r_state, n_state;
    logic [31:0] r_stale;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;       // scan index / sort outer index
    logic [CW-1:0] r_j, n_j;       // sort inner index, age-out write index
    logic [CW-1:0] r_removed, n_removed;
    logic        r_key, n_key;
    logic [2:0]  r_op, n_op;
    t_entry      r_req, n_req;
    t_entry      r_a, n_a;         // latched entry j-1 during sort
    logic [4:0]  r_idx, n_idx;
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_code, n_code;
    logic        r_rvalid, n_rvalid;
    t_entry      r_rd, n_rd;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    tpt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TAGS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );
    assign rdata = t_entry'(rdata_raw);

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;

    logic a_less_b;
    always_comb begin
        if (r_key) begin
            a_less_b = $signed(r_a.rssi) < $signed(rdata.rssi);
        end else begin
            a_less_b = r_a.last_seen < rdata.last_seen;
        end
    end

    logic [31:0] age;
    assign age = r_req.last_seen - rdata.last_seen;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i = r_i;
        n_j = r_j;
        n_removed = r_removed;
        n_key = r_key;
        n_op = r_op;
        n_req = r_req;
        n_a = r_a;
        n_idx = r_idx;
        n_ovalid = r_ovalid;
        n_code = r_code;
        n_rvalid = r_rvalid;
        n_rd = r_rd;
        we = 1'b0;
        waddr = r_i[AW-1:0];
        wdata = r_req;
        raddr = r_i[AW-1:0];

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_ovalid) begin
                    n_op = i_op;
                    n_req.tag_id = i_tag_id;
                    n_req.rssi = i_rssi;
                    n_req.status = i_status;
                    n_req.last_seen = i_now_sec;
                    n_idx = i_entry_index;
                    n_i = '0;
                    n_j = '0;
                    n_removed = '0;
                    n_code = UPD_FULL;
                    n_rvalid = 1'b0;
                    n_rd = '0;
                    case (i_op)
                        OP_UPDATE: n_state = S_UPD_RD;
                        OP_AGE: n_state = S_AGE_RD;
                        OP_SORT_TIME, OP_SORT_RSSI: begin
                            n_key = (i_op == OP_SORT_RSSI);
                            n_i = CW'(1);
                            n_j = CW'(1);
                            n_state = S_SRT_RA;
                        end
                        OP_READ: n_state = S_RD_WAIT;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_UPD_RD: begin
                if (r_i >= r_count) begin
                    if (r_count >= FULL) begin
                        n_code = UPD_FULL;
                    end else begin
                        we = 1'b1;
                        waddr = r_count[AW-1:0];
                        n_count = r_count + CW'(1);
                        n_code = UPD_ADDED;
                    end
                    n_state = S_OUT;
                end else begin
                    n_state = S_UPD_CK;
                end
            end
            S_UPD_CK: begin
                if (rdata.tag_id == r_req.tag_id) begin
                    we = 1'b1;
                    wdata = r_req;
                    if ($signed(r_req.rssi) <= $signed(rdata.rssi)) begin
                        wdata.rssi = rdata.rssi;
                    end
                    n_code = UPD_UPDATED;
                    n_state = S_OUT;
                end else begin
                    n_i = r_i + CW'(1);
                    n_state = S_UPD_RD;
                end
            end
            S_AGE_RD: begin
                if (r_i >= r_count) begin
                    n_count = r_j;
                    n_state = S_OUT;
                end else begin
                    n_state = S_AGE_CK;
                end
            end
            S_AGE_CK: begin
                // Survivors are written down to the compaction index; the
                // write index never passes the read index.
                if (age > r_stale) begin
                    n_removed = r_removed + CW'(1);
                end else begin
                    we = 1'b1;
                    waddr = r_j[AW-1:0];
                    wdata = rdata;
                    n_j = r_j + CW'(1);
                end
                n_i = r_i + CW'(1);
                n_state = S_AGE_RD;
            end
            S_RD_WAIT: begin
                raddr = AW'(r_idx);
                n_state = S_RD_DONE;
            end
            S_RD_DONE: begin
                if (32'(r_idx) < 32'(r_count)) begin
                    n_rvalid = 1'b1;
                    n_rd = rdata;
                end
                n_state = S_OUT;
            end
            S_SRT_RA: begin
                // j is the inner position; j == 0 ends this pass.
                if (r_i >= r_count) begin
                    n_state = S_OUT;
                end else if (r_j == '0) begin
                    n_i = r_i + CW'(1);
                    n_j = r_i + CW'(1);
                end else begin
                    raddr = r_j[AW-1:0] - AW'(1);
                    n_state = S_SRT_RB;
                end
            end
            S_SRT_RB: begin
                n_a = rdata;
                raddr = r_j[AW-1:0];
                n_state = S_SRT_CK;
            end
            S_SRT_CK: begin
                if (a_less_b) begin
                    we = 1'b1;
                    waddr = r_j[AW-1:0] - AW'(1);
                    wdata = rdata;
                    n_state = S_SRT_WB;
                end else begin
                    n_i = r_i + CW'(1);
                    n_j = r_i + CW'(1);
                    n_state = S_SRT_RA;
                end
            end
            S_SRT_WB: begin
                we = 1'b1;
                waddr = r_j[AW-1:0];
                wdata = r_a;
                n_j = r_j - CW'(1);
                n_state = S_SRT_RA;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_stale <= STALE_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                r_stale <= i_cfg_data;
            end
        end
        r_i <= n_i;
        r_j <= n_j;
        r_removed <= n_removed;
        r_key <= n_key;
        r_op <= n_op;
        r_req <= n_req;
        r_a <= n_a;
        r_idx <= n_idx;
        r_code <= n_code;
        r_rvalid <= n_rvalid;
        r_rd <= n_rd;
    end

    assign o_valid = r_ovalid;
    assign o_update_code = (r_op == OP_UPDATE) ? r_code : UPD_FULL;
    assign o_removed_count = 6'(r_removed);
    assign o_entry_count = 6'(r_count);
    assign o_read_valid = r_rvalid;
    assign o_read_tag_id = r_rd.tag_id;
    assign o_read_rssi = r_rd.rssi;
    assign o_read_status = r_rd.status;
    assign o_read_last_seen = r_rd.last_seen;

    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, r_count <= FULL, "entry count over capacity")
    `ASSERT_CLK(a_busy_no_out, i_clk, i_rst_n, (r_state != S_IDLE) |-> !r_ovalid, "result while busy")
    `ASSERT_CLK(a_age_compact, i_clk, i_rst_n, (r_state == S_AGE_CK) |-> (r_j <= r_i), "compaction overtook scan")
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_ovalid), "reset not idle")

endmodule

// ----- tb/tag_presence_table_with_aging_test.sv -----
`timescale 1ns / 100ps

module tag_presence_table_with_aging_test;
    import tpt_pkg::*;

    localparam int TABLE_DEPTH = 32;

    // One expected response of the table.
    typedef struct packed {
        logic [1:0]  update_code;
        logic [5:0]  removed_count;
        logic [5:0]  entry_count;
        logic        read_valid;
        logic [15:0] tag_id;
        logic [7:0]  rssi;
        logic [7:0]  status;
        logic [31:0] last_seen;
    } t_response;

    // The scoreboard keeps its own copy of the table and of the age
    // threshold, computes the response of every accepted request and
    // compares it with what the block returns.
    class tag_table_scoreboard;
        t_entry      shadow_table[TABLE_DEPTH];
        int          shadow_count;
        logic [31:0] stale_limit;
        t_response   pending_responses[$];
        int          error_count;
        int          response_count;
        int          full_count;
        int          removed_total;

        function new();
            shadow_count = 0;
            stale_limit = STALE_RESET;
            error_count = 0;
            response_count = 0;
            full_count = 0;
            removed_total = 0;
        endfunction

        // Returns 1 when entry a must move behind entry b in a descending sort.
        function bit ranks_lower(t_entry a, t_entry b, bit by_signal);
            if (by_signal) begin
                return $signed(a.rssi) < $signed(b.rssi);
            end
            return a.last_seen < b.last_seen;
        endfunction

        // Stable insertion sort, newest or strongest first.
        function void sort_entries(bit by_signal);
            t_entry moved;
            int j;
            for (int i = 1; i < shadow_count; i++) begin
                j = i;
                while (j > 0 && ranks_lower(shadow_table[j - 1], shadow_table[j], by_signal)) begin
                    moved = shadow_table[j];
                    shadow_table[j] = shadow_table[j - 1];
                    shadow_table[j - 1] = moved;
                    j--;
                end
            end
        endfunction

        function void note_request(logic [2:0] op, logic [15:0] tag_id, logic [7:0] rssi,
                                   logic [7:0] status, logic [31:0] now_sec,
                                   logic [4:0] entry_index);
            t_response resp;
            bit found;
            int kept;
            logic [31:0] age;
            resp = '{default: '0};
            case (op)
                OP_UPDATE: begin
                    found = 0;
                    for (int i = 0; i < shadow_count && !found; i++) begin
                        if (shadow_table[i].tag_id == tag_id) begin
                            if ($signed(rssi) > $signed(shadow_table[i].rssi)) begin
                                shadow_table[i].rssi = rssi;
                            end
                            shadow_table[i].status = status;
                            shadow_table[i].last_seen = now_sec;
                            found = 1;
                        end
                    end
                    if (found) begin
                        resp.update_code = UPD_UPDATED;
                    end else if (shadow_count >= TABLE_DEPTH) begin
                        resp.update_code = UPD_FULL;
                        full_count++;
                    end else begin
                        shadow_table[shadow_count] = '{tag_id, rssi, status, now_sec};
                        shadow_count++;
                        resp.update_code = UPD_ADDED;
                    end
                end
                OP_AGE: begin
                    kept = 0;
                    for (int i = 0; i < shadow_count; i++) begin
                        age = now_sec - shadow_table[i].last_seen;
                        if (age > stale_limit) begin
                            resp.removed_count++;
                        end else begin
                            shadow_table[kept] = shadow_table[i];
                            kept++;
                        end
                    end
                    removed_total += resp.removed_count;
                    shadow_count = kept;
                end
                OP_SORT_TIME: sort_entries(0);
                OP_SORT_RSSI: sort_entries(1);
                OP_READ: begin
                    if (entry_index < shadow_count) begin
                        resp.read_valid = 1;
                        resp.tag_id = shadow_table[entry_index].tag_id;
                        resp.rssi = shadow_table[entry_index].rssi;
                        resp.status = shadow_table[entry_index].status;
                        resp.last_seen = shadow_table[entry_index].last_seen;
                    end
                end
                default: ;
            endcase
            resp.entry_count = 6'(shadow_count);
            pending_responses.push_back(resp);
        endfunction

        function void check_response(t_response got);
            t_response want;
            response_count++;
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected response, entry_count %0d", $realtime,
                         got.entry_count);
                error_count++;
                return;
            end
            want = pending_responses.pop_front();
            if (got != want) begin
                $display("%0t: mismatch, expected code %0d removed %0d count %0d rv %0b",
                         $realtime, want.update_code, want.removed_count,
                         want.entry_count, want.read_valid);
                $display("    id %h rssi %h status %h seen %h", want.tag_id, want.rssi,
                         want.status, want.last_seen);
                $display("    actual code %0d removed %0d count %0d rv %0b",
                         got.update_code, got.removed_count, got.entry_count,
                         got.read_valid);
                $display("    id %h rssi %h status %h seen %h", got.tag_id, got.rssi,
                         got.status, got.last_seen);
                error_count++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [2:0]        i_op;
    logic [15:0]       i_tag_id;
    logic signed [7:0] i_rssi;
    logic [7:0]        i_status;
    logic [31:0]       i_now_sec;
    logic [4:0]        i_entry_index;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [31:0]       i_cfg_data;
    logic              o_valid;
    logic              i_ready;
    logic [1:0]        o_update_code;
    logic [5:0]        o_removed_count;
    logic [5:0]        o_entry_count;
    logic              o_read_valid;
    logic [15:0]       o_read_tag_id;
    logic signed [7:0] o_read_rssi;
    logic [7:0]        o_read_status;
    logic [31:0]       o_read_last_seen;

    tag_presence_table_with_aging i_dut (.*);

    tag_table_scoreboard tracker = new();

    // Idle percentages of the sender and receiver; the hold-off flag forces
    // the receiver to stall completely.
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    bit  stimulus_done;
    logic [31:0] clock_sec;
    int  requests_sent;
    int  sort_count;
    int  read_hits;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // The receiver decides its ready for the next edge at every rising
    // edge, and results are checked at the edge that accepts them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                tracker.check_response('{o_update_code, o_removed_count, o_entry_count,
                                         o_read_valid, o_read_tag_id, o_read_rssi,
                                         o_read_status, o_read_last_seen});
                if (o_read_valid) begin
                    read_hits++;
                end
            end
            i_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one request and returns once the block has accepted it. Valid
    // is left high for back-to-back requests and lowered only on an idle.
    task automatic send_request(logic [2:0] op, logic [15:0] tag_id, logic [7:0] rssi,
                                logic [7:0] status, logic [31:0] now_sec,
                                logic [4:0] entry_index);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_tag_id <= tag_id;
        i_rssi <= rssi;
        i_status <= status;
        i_now_sec <= now_sec;
        i_entry_index <= entry_index;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        tracker.note_request(op, tag_id, rssi, status, now_sec, entry_index);
        requests_sent++;
        if (op == OP_SORT_TIME || op == OP_SORT_RSSI) begin
            sort_count++;
        end
    endtask

    // Waits until every response is in and the block has gone quiet, then
    // writes the age threshold.
    task automatic write_stale_limit(logic [31:0] limit);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        tracker.stale_limit = limit;
    endtask

    // A sighting of a tag drawn from a small pool so that updates hit
    // existing entries often; the clock moves forward by a few seconds.
    task automatic send_sighting(int tag_pool);
        clock_sec = clock_sec + $urandom_range(20);
        send_request(OP_UPDATE, 16'(($urandom_range(tag_pool - 1) * 977) ^ 16'h5a00),
                     8'($urandom), 8'($urandom), clock_sec, '0);
    endtask

    // A random request: mostly sightings, then reads, age-outs and sorts,
    // and a few unused codes and fully random fields.
    task automatic send_random_request(int tag_pool);
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            send_sighting(tag_pool);
        end else if (pick < 72) begin
            send_request(OP_READ, 16'($urandom), 8'($urandom), 8'($urandom),
                         $urandom, 5'($urandom));
        end else if (pick < 80) begin
            send_request(OP_AGE, 16'($urandom), 8'($urandom), 8'($urandom),
                         clock_sec + $urandom_range(400), 5'($urandom));
        end else if (pick < 86) begin
            send_request(OP_SORT_TIME, 16'($urandom), 8'($urandom), 8'($urandom),
                         $urandom, 5'($urandom));
        end else if (pick < 92) begin
            send_request(OP_SORT_RSSI, 16'($urandom), 8'($urandom), 8'($urandom),
                         $urandom, 5'($urandom));
        end else if (pick < 95) begin
            send_request(3'($urandom_range(7, 5)), 16'($urandom), 8'($urandom),
                         8'($urandom), $urandom, 5'($urandom));
        end else begin
            // Random time, including wrap of the age subtraction.
            send_request(3'($urandom_range(1, 0)), 16'($urandom), 8'($urandom),
                         8'($urandom), $urandom, 5'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_op = OP_UPDATE;
        i_tag_id = '0;
        i_rssi = '0;
        i_status = '0;
        i_now_sec = '0;
        i_entry_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        send_idle_pct = 22;
        recv_idle_pct = 69;
        recv_hold = 0;
        stimulus_done = 0;
        clock_sec = 32'd1000;
        requests_sent = 0;
        sort_count = 0;
        read_hits = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: sorts and a read on an empty table, then extremes
        // of every field, repeat sightings, a single-entry sort and unused codes.
        send_request(OP_SORT_TIME, '0, '0, '0, '0, '0);
        send_request(OP_SORT_RSSI, '0, '0, '0, '0, '0);
        send_request(OP_READ, '0, '0, '0, '0, '0);
        send_request(OP_UPDATE, 16'hffff, 8'h80, 8'h00, 32'hffff_ffff, '0);
        send_request(OP_SORT_RSSI, '0, '0, '0, '0, '0);
        send_request(OP_UPDATE, 16'h0000, 8'h7f, 8'hff, 32'h0000_0000, '0);
        send_request(OP_UPDATE, 16'hffff, 8'h7f, 8'h55, 32'h0000_0010, '0);
        send_request(OP_UPDATE, 16'h0000, 8'h80, 8'haa, 32'h0000_0020, '0);
        send_request(OP_UPDATE, 16'h1234, 8'h00, 8'h01, 32'h0000_0020, '0);
        send_request(OP_SORT_TIME, '0, '0, '0, '0, '0);
        send_request(OP_SORT_RSSI, '0, '0, '0, '0, '0);
        for (int i = 0; i < 4; i++) begin
            send_request(OP_READ, '0, '0, '0, '0, 5'(i));
        end
        send_request(OP_READ, '0, '0, '0, '0, 5'd31);
        send_request(3'd5, '1, '1, '1, '1, '1);
        send_request(3'd6, '0, '0, '0, '0, '0);
        send_request(3'd7, '1, '1, '1, '1, '1);
        // The subtraction wraps here, so every entry looks very old.
        send_request(OP_AGE, '0, '0, '0, 32'h0000_0005, '0);
        send_request(OP_AGE, '0, '0, '0, 32'h0000_0005, '0);

        // Threshold zero: anything not seen this second goes.
        write_stale_limit(32'd0);
        send_request(OP_UPDATE, 16'h0042, 8'h10, 8'h10, clock_sec, '0);
        send_request(OP_UPDATE, 16'h0043, 8'h11, 8'h11, clock_sec + 1, '0);
        send_request(OP_AGE, '0, '0, '0, clock_sec + 1, '0);

        // Fill the table to overflow, with the largest threshold, then hold
        // the receiver off so the block backs up on its input.
        write_stale_limit(32'hffff_ffff);
        send_idle_pct = 0;
        recv_hold = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                recv_hold = 0;
            end
        join_none
        for (int i = 0; i < 40; i++) begin
            send_sighting(64);
        end
        send_request(OP_AGE, '0, '0, '0, clock_sec, '0);
        send_idle_pct = 22;

        // Random phases at several thresholds and idle patterns.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_stale_limit(32'd600);
                1: write_stale_limit(32'd60);
                2: write_stale_limit(32'($urandom));
                3: write_stale_limit(32'd150);
                4: write_stale_limit(32'hffff_ffff);
                default: write_stale_limit(32'd30);
            endcase
            if (phase == 2) begin
                send_idle_pct = 69;
                recv_idle_pct = 22;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 170; i++) begin
                send_random_request(phase == 4 ? 48 : 24);
            end
        end
        i_valid <= 1'b0;
        stimulus_done = 1;
    end

    initial begin
        @(posedge i_clk);
        wait (stimulus_done);
        while (tracker.pending_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
        $display("Sent %0d requests (%0d sorts), checked %0d responses.", requests_sent,
                 sort_count, tracker.response_count);
        $display("Reads of live entries %0d, full reports %0d, entries aged out %0d.",
                 read_hits, tracker.full_count, tracker.removed_total);
        if (tracker.error_count == 0 && tracker.pending_responses.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Worst case is roughly 1100 requests, all of them full reverse-order
    // sorts with stalls, near 28 ms; this bound sits well above that.
    initial begin
        #150ms;
        $display("Timeout with %0d responses outstanding.", tracker.pending_responses.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
